// ===== design/multi_channel_breathing_ramp_unit_defines.svh =====
// Assertion macros used by the checker file of the breathing ramp unit.
// Depends on nothing; expects clk, and for MCBR_ASSERT also rst_n, in the scope of each use.
`ifndef MULTI_CHANNEL_BREATHING_RAMP_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_BREATHING_RAMP_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MCBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MCBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mcbr_pkg.sv =====
// Package of the breathing ramp unit: payload structs, codes and defaults.
// Used by every module of the unit but mcbr_ram, and by its checker.
package mcbr_pkg;

  // Defaults of the top level parameters
  localparam int NUM_CHANNELS_DEF = 32;
  localparam int LEVEL_BITS_DEF   = 12;

  // Fixed field widths of the channels
  localparam int CH_BITS      = 5;
  localparam int FIELD_BITS   = 12;
  localparam int CFG_IDX_BITS = 1;

  // Configuration reset values
  localparam logic [FIELD_BITS-1:0] LEVEL_MAX_RST = 12'd2500;
  localparam logic [FIELD_BITS-1:0] LEVEL_MIN_RST = 12'd0;

  // Item function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_MAX = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_MIN = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [CH_BITS-1:0]    channel;
    logic [FIELD_BITS-1:0] step;
    logic                  rising;
    logic [FIELD_BITS-1:0] start_level;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0]    out_channel;
    logic [FIELD_BITS-1:0] level;
    logic                  last;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_PUT  = 4'b1000
  } state_t;

endpackage

// ===== design/mcbr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module mcbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mcbr_advance.sv =====
// One ramp step of a channel: move the level by the step, clamp and turn.
// Depends on mcbr_pkg for the limit width.
module mcbr_advance import mcbr_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic [LEVEL_BITS-1:0] level,
  input  logic [LEVEL_BITS-1:0] step,
  input  logic                  rising,
  input  logic [FIELD_BITS-1:0] lvl_max,
  input  logic [FIELD_BITS-1:0] lvl_min,
  output logic [LEVEL_BITS-1:0] new_level,
  output logic                  new_rising
);

  // Wide enough that neither sum wraps
  localparam int CW = ((LEVEL_BITS > FIELD_BITS) ? LEVEL_BITS : FIELD_BITS) + 1;

  logic [CW-1:0] lv_w, st_w, max_w, min_w, sum_w, thr_w, res_w;

  assign lv_w  = CW'(level);
  assign st_w  = CW'(step);
  assign max_w = CW'(lvl_max);
  assign min_w = CW'(lvl_min);
  assign sum_w = lv_w + st_w;
  assign thr_w = min_w + st_w;

  // Clamp at the top going up, at the bottom going down
  always_comb begin
    if (rising) begin
      if (sum_w >= max_w) begin
        res_w      = max_w;
        new_rising = 1'b0;
      end else begin
        res_w      = sum_w;
        new_rising = 1'b1;
      end
    end else begin
      if (lv_w <= thr_w) begin
        res_w      = min_w;
        new_rising = 1'b1;
      end else begin
        res_w      = lv_w - st_w;
        new_rising = 1'b0;
      end
    end
  end

  assign new_level = res_w[LEVEL_BITS-1:0];

endmodule

// ===== design/multi_channel_breathing_ramp_unit.sv =====
// Top level of the breathing ramp unit: sequencer, enable bits, channel RAM.
// Depends on mcbr_pkg, mcbr_ram and mcbr_advance.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_stall   | in_item_t
//   out_       | output    | out_valid/out_stall | out_item_t
//   cfg_       | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A set item for a valid channel passes through the transfer and the output load.
// A tick with a channel enabled passes through the transfer, a scan step per disabled
// channel below the highest enabled one and, per enabled channel, the RAM read, the update
// and write back, and the output load, all through the single channel RAM port pair.
// Reset clears the enable bits and loads the default limits; the channel RAM is not
// cleared.
// A stalled output holds the walk in its output load step; the input is
// stalled while a tick or a set result is in progress.
module multi_channel_breathing_ramp_unit import mcbr_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int LEVEL_BITS   = LEVEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_data
);

  localparam int IDXW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNTW  = $clog2(NUM_CHANNELS + 1);
  localparam int WORDW = 2 * LEVEL_BITS + 1;

  state_t                  state_r, state_nxt;
  logic [NUM_CHANNELS-1:0] en_r, en_nxt;
  logic [CNTW-1:0]         en_cnt_r, en_cnt_nxt;
  logic [CNTW-1:0]         emit_cnt_r, emit_cnt_nxt;
  logic [IDXW-1:0]         idx_r, idx_nxt;
  logic [FIELD_BITS-1:0]   lvl_max_r, lvl_min_r;
  out_item_t               res_r, res_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_xfer, slot_free;
  logic [CH_BITS+IDXW-1:0] ch_ext;
  logic                    ch_ok;
  logic [IDXW-1:0]         set_idx;
  logic [FIELD_BITS+LEVEL_BITS-1:0] step_ext, start_ext;
  logic [LEVEL_BITS-1:0]   set_step, set_level;

  logic                    ram_we;
  logic [IDXW-1:0]         ram_waddr;
  logic [WORDW-1:0]        ram_wdata, ram_rdata;

  logic [LEVEL_BITS-1:0]   rd_level, rd_step, adv_level;
  logic                    rd_rising, adv_rising;
  logic [LEVEL_BITS+FIELD_BITS-1:0] adv_ext, set_lv_ext;
  logic [IDXW+CH_BITS-1:0] idx_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;

  // Decode the set item fields
  assign ch_ext    = {{IDXW{1'b0}}, in_data.channel};
  assign ch_ok     = ch_ext < (CH_BITS + IDXW)'(NUM_CHANNELS);
  assign set_idx   = ch_ext[IDXW-1:0];
  assign step_ext  = {{LEVEL_BITS{1'b0}}, in_data.step};
  assign start_ext = {{LEVEL_BITS{1'b0}}, in_data.start_level};
  assign set_step  = step_ext[LEVEL_BITS-1:0];
  assign set_level = start_ext[LEVEL_BITS-1:0];
  assign set_lv_ext = {{FIELD_BITS{1'b0}}, set_level};

  // Split the channel word read back from RAM
  assign {rd_rising, rd_step, rd_level} = ram_rdata;
  assign adv_ext = {{FIELD_BITS{1'b0}}, adv_level};
  assign idx_ext = {{CH_BITS{1'b0}}, idx_r};

  mcbr_advance #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_adv (
    .level     (rd_level),
    .step      (rd_step),
    .rising    (rd_rising),
    .lvl_max   (lvl_max_r),
    .lvl_min   (lvl_min_r),
    .new_level (adv_level),
    .new_rising(adv_rising)
  );

  mcbr_ram #(
    .WIDTH(WORDW),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // Sequence set items and the channel walk of a tick
  always_comb begin
    state_nxt    = state_r;
    en_nxt       = en_r;
    en_cnt_nxt   = en_cnt_r;
    emit_cnt_nxt = emit_cnt_r;
    idx_nxt      = idx_r;
    res_nxt      = res_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r;
    ram_wdata    = {adv_rising, rd_step, adv_level};
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.func == FUNC_SET) begin
            if (ch_ok) begin
              ram_we              = 1'b1;
              ram_waddr           = set_idx;
              ram_wdata           = {in_data.rising, set_step, set_level};
              en_nxt[set_idx]     = 1'b1;
              if (!en_r[set_idx]) begin
                en_cnt_nxt = en_cnt_r + CNTW'(1);
              end
              res_nxt.out_channel = in_data.channel;
              res_nxt.level       = set_lv_ext[FIELD_BITS-1:0];
              res_nxt.last        = 1'b1;
              state_nxt           = S_PUT;
            end
          end else if (en_cnt_r != '0) begin
            idx_nxt      = '0;
            emit_cnt_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read is issued at idx_r; skip disabled channels
        if (en_r[idx_r]) begin
          state_nxt = S_READ;
        end else begin
          idx_nxt = idx_r + IDXW'(1);
        end
      end
      S_READ: begin
        ram_we              = 1'b1;
        emit_cnt_nxt        = emit_cnt_r + CNTW'(1);
        res_nxt.out_channel = idx_ext[CH_BITS-1:0];
        res_nxt.level       = adv_ext[FIELD_BITS-1:0];
        res_nxt.last        = (emit_cnt_r + CNTW'(1)) == en_cnt_r;
        state_nxt           = S_PUT;
      end
      S_PUT: begin
        if (slot_free) begin
          if (res_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDXW'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load the pending result, drop it once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (state_r == S_PUT && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= '0;
      en_cnt_r    <= '0;
      emit_cnt_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      lvl_max_r   <= LEVEL_MAX_RST;
      lvl_min_r   <= LEVEL_MIN_RST;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      en_cnt_r    <= en_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL_MAX: lvl_max_r <= cfg_data;
          CFG_LEVEL_MIN: lvl_min_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/mcbr_checker.sv =====
// Port checker of the breathing ramp unit, bound to the top level.
// Depends on mcbr_pkg and multi_channel_breathing_ramp_unit_defines.svh.
`include "multi_channel_breathing_ramp_unit_defines.svh"

module mcbr_checker import mcbr_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input in_item_t                in_data,
  input logic                    out_valid,
  input logic                    out_stall,
  input out_item_t               out_data,
  input logic                    cfg_valid,
  input logic                    cfg_ready
);

  logic set_xfer;

  assign set_xfer = in_valid && !in_stall && (in_data.func == FUNC_SET) &&
                    (int'(in_data.channel) < NUM_CHANNELS);

  // Reset leaves no result and an open input
  `MCBR_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid && !in_stall), "reset did not clear")

  // A stalled result holds
  `MCBR_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")

  // A set into an empty output shows its channel marked last via res_r and out_data_r
  `MCBR_ASSERT(a_set_result, (set_xfer && !out_valid) |=> ##1 (out_valid && out_data.last && (out_data.out_channel == $past(in_data.channel, 2))), "set result missing")

  // Configuration is always taken
  `MCBR_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind multi_channel_breathing_ramp_unit mcbr_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_mcbr_checker (.*);
